>>> rtl/core/sed_pkg.sv
package sed_pkg;

	localparam int SUM_BITS   = 64;
	localparam int DIST_BITS  = 32;
	localparam int ROOT_STEPS = DIST_BITS;
	localparam int STEP_BITS  = $clog2(ROOT_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROOT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic root_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic root_last;
		logic out_busy;
	} stat_t;

endpackage

>>> rtl/core/sed_ctrl.sv
module sed_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          end_of_pair,
	input  sed_pkg::stat_t stat,
	output sed_pkg::cmd_t  cmd
);
	import sed_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = end_of_pair ? ST_ROOT : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_FIN;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (stat.root_last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				// Wait until the output register is free to take this item's result.
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/sed_dp.sv
module sed_dp #(
	parameter int INDEX_BITS = 20,
	parameter int VALUE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sed_pkg::cmd_t                 cmd,
	output sed_pkg::stat_t                stat,
	input  logic                          a_present,
	input  logic [INDEX_BITS-1:0]         a_index,
	input  logic [VALUE_BITS-1:0]         a_value,
	input  logic                          b_present,
	input  logic [INDEX_BITS-1:0]         b_index,
	input  logic [VALUE_BITS-1:0]         b_value,
	input  logic                          end_of_pair,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          take_a,
	output logic                          take_b,
	output logic [sed_pkg::DIST_BITS-1:0] distance,
	output logic                          done_res,
	output logic                          saturated
);
	import sed_pkg::*;

	localparam int SQ_BITS  = 2 * VALUE_BITS;
	localparam int REM_BITS = DIST_BITS + 3;

	logic                  sel_a;
	logic                  sel_b;
	logic [VALUE_BITS-1:0] op;

	logic [VALUE_BITS-1:0] op_q;
	logic                  ta_q;
	logic                  tb_q;
	logic                  end_q;
	logic [SQ_BITS-1:0]    sq_q;

	logic [SUM_BITS-1:0]   sum_q;
	logic                  ovf_q;
	logic [SUM_BITS:0]     sum_ext;
	logic                  ovf;

	logic [SUM_BITS-1:0]   rad_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [DIST_BITS-1:0]  root_q;
	logic [STEP_BITS-1:0]  cnt_q;
	logic [REM_BITS-1:0]   rem_next;
	logic [REM_BITS-1:0]   trial;
	logic                  ge;

	logic                  out_valid_q;

	// Merge decision on the two offered heads.
	always_comb begin
		sel_a = 1'b0;
		sel_b = 1'b0;
		op    = '0;
		if (a_present && b_present) begin
			if (a_index == b_index) begin
				sel_a = 1'b1;
				sel_b = 1'b1;
				op    = (a_value >= b_value) ? (a_value - b_value) : (b_value - a_value);
			end else if (a_index < b_index) begin
				sel_a = 1'b1;
				op    = a_value;
			end else begin
				sel_b = 1'b1;
				op    = b_value;
			end
		end else if (a_present) begin
			sel_a = 1'b1;
			op    = a_value;
		end else if (b_present) begin
			sel_b = 1'b1;
			op    = b_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			ta_q  <= sel_a & ~end_of_pair;
			tb_q  <= sel_b & ~end_of_pair;
			end_q <= end_of_pair;
		end
		if (cmd.mul) begin
			sq_q <= SQ_BITS'(op_q) * SQ_BITS'(op_q);
		end
	end

	assign sum_ext = {1'b0, sum_q} + (SUM_BITS + 1)'(sq_q);
	assign ovf     = sum_ext[SUM_BITS];

	// Restoring square root, one result bit per step, two radicand bits consumed each step.
	assign rem_next = {rem_q[REM_BITS-3:0], rad_q[SUM_BITS-1 -: 2]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign ge       = (rem_next >= trial);

	always_ff @(posedge clk) begin
		if (cmd.load && end_of_pair) begin
			rad_q  <= sum_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[SUM_BITS-3:0], 2'b00};
			rem_q  <= ge ? (rem_next - trial) : rem_next;
			root_q <= {root_q[DIST_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= STEP_BITS'(ROOT_STEPS - 1);
		end else if (cmd.root_step) begin
			cnt_q <= cnt_q - STEP_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.finish) begin
			if (end_q) begin
				sum_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= ovf ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
				ovf_q <= ovf_q | ovf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			take_a    <= ta_q;
			take_b    <= tb_q;
			done_res  <= end_q;
			distance  <= end_q ? root_q : '0;
			saturated <= end_q ? ovf_q : (ovf_q | ovf);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.root_last = (cnt_q == '0);
	assign stat.out_busy  = out_valid_q & out_stall;

endmodule

>>> rtl/core/sparse_euclidean_distance.sv
// Channel | Handshake           | Payload
// input   | in_valid, in_stall   | a_present a_index a_value b_present b_index b_value end_of_pair
// output  | out_valid, out_stall | take_a take_b distance done_res saturated
//
// A merge item passes operand select, square in the multiplier, then saturating 64-bit
// accumulate on its way from acceptance to its result register.
// For an end item, the square root unit resolves one result bit per cycle.
// A new item is accepted once the previous one has reached the output register.
// Reset clears the sum, the sticky overflow flag and the handshake state.
// A stalled output holds its item; a finished result waits in its state until the register frees.
module sparse_euclidean_distance #(
	parameter int INDEX_BITS = 20,
	parameter int VALUE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          a_present,
	input  logic [INDEX_BITS-1:0]         a_index,
	input  logic [VALUE_BITS-1:0]         a_value,
	input  logic                          b_present,
	input  logic [INDEX_BITS-1:0]         b_index,
	input  logic [VALUE_BITS-1:0]         b_value,
	input  logic                          end_of_pair,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          take_a,
	output logic                          take_b,
	output logic [sed_pkg::DIST_BITS-1:0] distance,
	output logic                          done_res,
	output logic                          saturated
);
	import sed_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	sed_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.end_of_pair (end_of_pair),
		.stat        (stat),
		.cmd         (cmd)
	);

	sed_dp #(
		.INDEX_BITS (INDEX_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.a_present   (a_present),
		.a_index     (a_index),
		.a_value     (a_value),
		.b_present   (b_present),
		.b_index     (b_index),
		.b_value     (b_value),
		.end_of_pair (end_of_pair),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.take_a      (take_a),
		.take_b      (take_b),
		.distance    (distance),
		.done_res    (done_res),
		.saturated   (saturated)
	);

endmodule

>>> rtl/core/sed_checker.sv
module sed_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          take_a,
	input logic                          take_b,
	input logic [sed_pkg::DIST_BITS-1:0] distance,
	input logic                          done_res
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	// The block works on one item at a time, so an accepted item closes the input.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	a_end_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !take_a && !take_b)
		else $error("end item consumed a head");

	a_merge_no_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> distance == '0)
		else $error("merge item carries a distance");

endmodule

bind sparse_euclidean_distance sed_checker u_sed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.take_a    (take_a),
	.take_b    (take_b),
	.distance  (distance),
	.done_res  (done_res)
);
